// ===== rtl/ppum_pkg.sv =====
// ----------------------------------------------------------------------------
// ppum_pkg
// Shared types, constants and weight tables for the partial permutation
// unranking overestimate checker.
// ----------------------------------------------------------------------------
package ppum_pkg;

  localparam int unsigned NumCells   = 16;
  localparam int unsigned NumDigits  = 8;   // digits that place a pattern tile
  localparam int unsigned RankW      = 32;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned SumW       = 6;   // at most 8 tiles * 6 moves

  localparam logic [RankW-1:0] TotalMode0 = 32'd518918400;   // P(16,8)
  localparam logic [RankW-1:0] TotalMode1 = 32'd4151347200;  // P(16,9)

  localparam logic CfgIdxMode  = 1'b0;
  localparam logic CfgIdxDelta = 1'b1;

  typedef logic [NumCells-1:0][3:0] ppum_cells_t;

  typedef struct packed {
    logic              valid;
    logic              bad;
    logic [RankW-1:0]  rank;
    logic [RankW-1:0]  rem;
    ppum_cells_t       cells;
    logic [SumW-1:0]   sum;
    logic [ByteW-1:0]  pdb;
    logic [ByteW-1:0]  pred;
  } ppum_stage_t;

  // Mixed-radix weight P(15-i, m-i-1) of digit i for each mode.
  function automatic logic [RankW-1:0] ppum_weight(input logic mode, input logic [2:0] i);
    logic [RankW-1:0] w;
    w = '0;
    if (!mode) begin
      case (i)
        3'd0: w = 32'd32432400;
        3'd1: w = 32'd2162160;
        3'd2: w = 32'd154440;
        3'd3: w = 32'd11880;
        3'd4: w = 32'd990;
        3'd5: w = 32'd90;
        3'd6: w = 32'd9;
        3'd7: w = 32'd1;
        default: w = 32'd1;
      endcase
    end else begin
      case (i)
        3'd0: w = 32'd259459200;
        3'd1: w = 32'd17297280;
        3'd2: w = 32'd1235520;
        3'd3: w = 32'd95040;
        3'd4: w = 32'd7920;
        3'd5: w = 32'd720;
        3'd6: w = 32'd72;
        3'd7: w = 32'd8;
        default: w = 32'd1;
      endcase
    end
    return w;
  endfunction

endpackage

// ===== rtl/partial_perm_unrank_manhattan_overcheck.sv =====
// ----------------------------------------------------------------------------
// partial_perm_unrank_manhattan_overcheck
// Pattern-database overestimate checker for a 4x4 sliding-tile puzzle.
// ----------------------------------------------------------------------------
// Input beats on s_axis carry a rank, the stored database byte and a
// predicted delta. The rank is unranked into 8 cells, the Manhattan
// distance of the pattern tiles is summed and the true delta is formed.
// A beat leaves on m_axis only when the prediction overshoots the true
// delta, or when the rank is out of range (tuser set, overshoot 0).
// Configuration: cfg_we writes cfg_data to register cfg_addr
// (0 = pattern mode, 1 = delta clamp); write only while the block is idle.
// From the accepting edge the beat is range-checked and registered, then
// passes eight digit stages (one compare-subtract divider per digit) and
// the check stage, each registered, before it reaches m_axis_tvalid.
// Throughput is one beat per cycle, but a stall on m_axis freezes the whole
// pipeline together with s_axis_tready; nothing is dropped or repeated.
// Synchronous reset clears all valid bits and loads the register resets.
// ----------------------------------------------------------------------------
module partial_perm_unrank_manhattan_overcheck import ppum_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_addr,
  input  logic [7:0]  cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [47:0] s_axis_tdata,   // state_rank[31:0], pdb_value[39:32], predicted_delta[47:40]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // record_rank[31:0], over_amount[39:32]
  output logic [0:0]  m_axis_tuser    // bad_rank[0]
);

  logic             pattern_mode;
  logic [ByteW-1:0] delta_cap;
  logic             advance;
  ppum_stage_t      pipe [NumDigits+1];
  ppum_stage_t      s0_next;
  logic [RankW-1:0] rank_in;

  // Hold configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_mode <= 1'b0;
      delta_cap    <= 8'hFF;
    end else if (cfg_we) begin
      case (cfg_addr)
        CfgIdxMode:  pattern_mode <= cfg_data[0];
        CfgIdxDelta: delta_cap    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = advance;
  assign rank_in       = s_axis_tdata[31:0];

  // Range check and load the full cell list
  always_comb begin
    s0_next.valid = s_axis_tvalid;
    s0_next.bad   = rank_in >= (pattern_mode ? TotalMode1 : TotalMode0);
    s0_next.rank  = rank_in;
    s0_next.rem   = rank_in;
    for (int j = 0; j < NumCells; j++) s0_next.cells[j] = 4'(j);
    s0_next.sum   = '0;
    s0_next.pdb   = s_axis_tdata[39:32];
    s0_next.pred  = s_axis_tdata[47:40];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pipe[0].valid <= 1'b0;
    end else if (advance) begin
      pipe[0] <= s0_next;
    end
  end

  // Advance one digit per stage
  for (genvar i = 0; i < NumDigits; i++) begin : g_digit
    ppum_digit #(.STAGE(i)) u_digit (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .mode    (pattern_mode),
      .din     (pipe[i]),
      .dout    (pipe[i+1])
    );
  end

  ppum_check u_check (
    .clk       (clk),
    .rst       (rst),
    .delta_cap (delta_cap),
    .din       (pipe[NumDigits]),
    .out_ready (m_axis_tready),
    .advance   (advance),
    .out_valid (m_axis_tvalid),
    .out_rank  (m_axis_tdata[31:0]),
    .out_over  (m_axis_tdata[39:32]),
    .out_bad   (m_axis_tuser[0])
  );

endmodule

// ===== rtl/ppum_digit.sv =====
// ----------------------------------------------------------------------------
// ppum_digit
// One unranking stage: extract a digit, take the cell out of the available
// list and add that tile's Manhattan distance.
// ----------------------------------------------------------------------------
module ppum_digit import ppum_pkg::*; #(
  parameter int unsigned STAGE = 0
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        advance,
  input  logic        mode,
  input  ppum_stage_t din,
  output ppum_stage_t dout
);

  localparam logic [3:0] Left = 4'(NumCells - 1 - STAGE);  // largest legal index

  logic [RankW-1:0] w;
  logic [RankW:0]   r;
  logic [RankW:0]   sh;
  logic [3:0]       q;
  logic [3:0]       idx;
  logic [3:0]       p;
  logic [3:0]       g;
  logic [1:0]       dr;
  logic [1:0]       dc;
  logic [2:0]       step_dist;
  ppum_cells_t      nxt;
  ppum_stage_t      dout_next;

  always_comb begin
    w = ppum_weight(mode, 3'(STAGE));
    r = {1'b0, din.rem};
    q = '0;
    for (int b = 3; b >= 0; b--) begin
      sh = {1'b0, w} << b;
      if (r >= sh) begin
        r    = r - sh;
        q[b] = 1'b1;
      end
    end
    idx = (q > Left) ? Left : q;
    p   = din.cells[idx];
    for (int j = 0; j < NumCells; j++) begin
      if (4'(j) < idx || j == NumCells - 1) nxt[j] = din.cells[j];
      else                                  nxt[j] = din.cells[(j + 1) % NumCells];
    end
    g    = mode ? 4'(STAGE + 7) : 4'(STAGE);
    dr   = (p[3:2] > g[3:2]) ? p[3:2] - g[3:2] : g[3:2] - p[3:2];
    dc   = (p[1:0] > g[1:0]) ? p[1:0] - g[1:0] : g[1:0] - p[1:0];
    step_dist = {1'b0, dr} + {1'b0, dc};

    dout_next       = din;
    dout_next.rem   = r[RankW-1:0];
    dout_next.cells = nxt;
    // the blank is the last digit in mode 0; skip it
    if (mode || STAGE < NumDigits - 1)
      dout_next.sum = din.sum + SumW'(step_dist);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (advance) begin
      dout <= dout_next;
    end
  end

endmodule

// ===== rtl/ppum_check.sv =====
// ----------------------------------------------------------------------------
// ppum_check
// Final stage: clamp the true delta, compare with the prediction and hold
// the result beat in the output register.
// ----------------------------------------------------------------------------
module ppum_check import ppum_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic [ByteW-1:0]  delta_cap,
  input  ppum_stage_t       din,
  input  logic              out_ready,
  output logic              advance,
  output logic              out_valid,
  output logic [RankW-1:0]  out_rank,
  output logic [ByteW-1:0]  out_over,
  output logic              out_bad
);

  logic [ByteW-1:0] tru;
  logic             over;

  always_comb begin
    tru  = ({2'b00, din.sum} < din.pdb) ? din.pdb - ByteW'(din.sum) : '0;
    if (tru > delta_cap) tru = delta_cap;
    over = din.pred > tru;
  end

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= din.valid && (din.bad || over);
      out_rank  <= din.rank;
      out_over  <= din.bad ? '0 : din.pred - tru;
      out_bad   <= din.bad;
    end
  end

endmodule
